[src/nmea_sb_pkg.sv]
// Shared constants, codes and helpers for the NMEA sentence builder.
// No dependencies; imported by nmea_sentence_builder_unit.
`default_nettype none

package nmea_sb_pkg;

    // Default parameter values
    localparam int INT_BITS_DEF = 32;
    localparam int ID_CHARS_DEF = 5;

    // Configuration register layout
    localparam int ID_REG_W   = 40;
    localparam int CFG_DATA_W = ID_REG_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IDENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CRLF  = 1'b1;

    // Input commands
    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_FIELD = 3'd1,
        CMD_BYTE  = 3'd2,
        CMD_INT   = 3'd3,
        CMD_FINAL = 3'd4
    } cmd_t;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_AFTER_FIN = 2'd1;
    localparam logic [1:0] ST_NO_START  = 2'd2;

    // Sentence characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [3:0] NIB_MASK  = 4'hF;

    // Uppercase hex digit for one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
            c = CH_ZERO + {4'h0, nib & NIB_MASK};
        else
            c = 8'h41 + {4'h0, nib - 4'd10};
        return c;
    endfunction

    // Decimal digits needed for values below 2**n (elaboration only)
    function automatic int dec_digits(input int n);
        longint unsigned v;
        int d;
        v = 64'd1 << n;
        d = 0;
        while (v != 0) begin
            v = v / 10;
            d = d + 1;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[src/nmea_sentence_builder_unit.sv]
// Top level of the NMEA 0183 sentence builder: command sequencer, shared
// shift-add-3 binary-to-decimal unit and output register. Uses nmea_sb_pkg.
`default_nettype none

// Usage
//   Command channel (cmd_valid/cmd_ready, command, field_value): one beat per
//   command. Start, begin field, field byte, integer field, finalize.
//   Result channel (res_valid/res_ready, out_char, char_valid, run_last,
//   status): one beat per sentence character or per status-only result;
//   run_last marks the final beat caused by a command.
//   Config port (cfg_we, cfg_index, cfg_data): index 0 identifier, index 1
//   CR LF enable; write only while no command is in flight.
// Timing
//   One command is in work at a time; cmd_ready is high only when idle.
//   The first beat of an accepted command enters the output register once it is ready and that register is free.
//   Character beats leave at one per cycle while the receiver takes them.
//   Start: ID_CHARS+1 beats. Finalize: 3 or 5 beats. Field/status: 1 beat.
//   Integer field: min(INT_BITS,32) magnitude bits through the shift-add-3
//   converter (one magnitude bit per cycle), then leading zero digits are
//   stripped, keeping one, then ',' , optional '-', and the digits.
// Reset clears the sentence state, the sticky error and the output valid flag;
// identifier resets to zero and CR LF enable to one.
// A stall on res_ready holds the output register and the next pending beat.
module nmea_sentence_builder_unit #(
    parameter int INT_BITS = nmea_sb_pkg::INT_BITS_DEF,
    parameter int ID_CHARS = nmea_sb_pkg::ID_CHARS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // command channel
    input  wire logic                                  cmd_valid,
    output logic                                       cmd_ready,
    input  wire logic [2:0]                            command,
    input  wire logic signed [31:0]                    field_value,
    // result channel
    output logic                                       res_valid,
    input  wire logic                                  res_ready,
    output logic [7:0]                                 out_char,
    output logic                                       char_valid,
    output logic                                       run_last,
    output logic [1:0]                                 status,
    // configuration
    input  wire logic                                  cfg_we,
    input  wire logic [nmea_sb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [nmea_sb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import nmea_sb_pkg::*;

    // Effective integer width and digit budget
    localparam int NB    = (INT_BITS < 32) ? INT_BITS : 32;
    localparam int ND    = dec_digits(NB);
    localparam int BCD_W = 4 * ND;
    localparam int IDW   = 8 * ID_CHARS;
    localparam int CMAX0 = (NB > ND) ? NB : ND;
    localparam int CMAX1 = (CMAX0 > ID_CHARS) ? CMAX0 : ID_CHARS;
    localparam int CMAX  = (CMAX1 > 4) ? CMAX1 : 4;
    localparam int CNT_W = $clog2(CMAX + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ONE   = 9'b000000010,
        S_ID    = 9'b000000100,
        S_FIN   = 9'b000001000,
        S_CONV  = 9'b000010000,
        S_SKIP  = 9'b000100000,
        S_COMMA = 9'b001000000,
        S_MINUS = 9'b010000000,
        S_DIG   = 9'b100000000
    } state_t;

    // Sequencer and sentence state
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [7:0]             xor_reg, xor_next;
    logic                   open_reg, open_next;
    logic                   closed_reg, closed_next;
    logic [1:0]             err_reg, err_next;

    // Configuration
    logic [ID_REG_W-1:0]    ident_reg;
    logic                   crlf_reg;

    // Work registers
    logic [IDW-1:0]         id_sr_reg, id_sr_next;
    logic [7:0]             ch_reg, ch_next;
    logic                   one_cv_reg, one_cv_next;
    logic [1:0]             one_st_reg, one_st_next;
    logic                   one_xor_reg, one_xor_next;
    logic [NB-1:0]          mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic                   neg_reg, neg_next;

    // Output register
    logic                   res_valid_reg;
    logic [7:0]             out_char_reg;
    logic                   char_valid_reg;
    logic                   run_last_reg;
    logic [1:0]             status_reg;

    // Beat request from the sequencer
    logic                   emit_en;
    logic [7:0]             emit_char;
    logic                   emit_cv;
    logic                   emit_last;
    logic [1:0]             emit_st;
    logic                   emit_xor;
    logic                   can_load;
    logic                   emit_fire;

    // Shared converter datapath
    logic [BCD_W-1:0]       bcd_adj;
    logic [3:0]             top_digit;
    logic [NB-1:0]          int_val;

    assign cmd_ready = (state_reg == S_IDLE);
    assign can_load  = !res_valid_reg || res_ready;
    assign emit_fire = emit_en && can_load;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign int_val   = field_value[NB-1:0];

    // Add 3 to every BCD digit of five or more before the shift
    always_comb
    begin
        for (int d = 0; d < ND; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    // Beat selection per state
    always_comb
    begin
        emit_en   = 1'b0;
        emit_char = 8'h00;
        emit_cv   = 1'b1;
        emit_last = 1'b0;
        emit_st   = ST_OK;
        emit_xor  = 1'b0;
        unique case (state_reg)
            S_ONE:
            begin
                emit_en   = 1'b1;
                emit_char = ch_reg;
                emit_cv   = one_cv_reg;
                emit_last = 1'b1;
                emit_st   = one_st_reg;
                emit_xor  = one_xor_reg;
            end
            S_ID:
            begin
                emit_en   = 1'b1;
                emit_char = (cnt_reg == '0) ? CH_DOLLAR : id_sr_reg[IDW-1 -: 8];
                emit_xor  = (cnt_reg != '0);
                emit_last = (cnt_reg == CNT_W'(ID_CHARS));
            end
            S_FIN:
            begin
                emit_en = 1'b1;
                case (cnt_reg)
                    CNT_W'(0): emit_char = CH_STAR;
                    CNT_W'(1): emit_char = hex_char(xor_reg[7:4]);
                    CNT_W'(2): emit_char = hex_char(xor_reg[3:0]);
                    CNT_W'(3): emit_char = CH_CR;
                    default:   emit_char = CH_LF;
                endcase
                emit_last = ((cnt_reg == CNT_W'(2)) && !crlf_reg)
                          || (cnt_reg == CNT_W'(4));
            end
            S_COMMA:
            begin
                emit_en   = 1'b1;
                emit_char = CH_COMMA;
                emit_xor  = 1'b1;
            end
            S_MINUS:
            begin
                emit_en   = 1'b1;
                emit_char = CH_MINUS;
                emit_xor  = 1'b1;
            end
            S_DIG:
            begin
                emit_en   = 1'b1;
                emit_char = CH_ZERO + {4'h0, top_digit};
                emit_xor  = 1'b1;
                emit_last = (cnt_reg == CNT_W'(1));
            end
            default:
            begin
                emit_en = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        xor_next     = xor_reg;
        open_next    = open_reg;
        closed_next  = closed_reg;
        err_next     = err_reg;
        id_sr_next   = id_sr_reg;
        ch_next      = ch_reg;
        one_cv_next  = one_cv_reg;
        one_st_next  = one_st_reg;
        one_xor_next = one_xor_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;

        if (emit_fire && emit_xor)
            xor_next = xor_reg ^ emit_char;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    // Default outcome: one status-only beat with the sticky error
                    state_next   = S_ONE;
                    ch_next      = 8'h00;
                    one_cv_next  = 1'b0;
                    one_st_next  = err_reg;
                    one_xor_next = 1'b0;
                    if (cmd_t'(command) == CMD_START)
                    begin
                        err_next    = ST_OK;
                        open_next   = 1'b1;
                        closed_next = 1'b0;
                        xor_next    = 8'h00;
                        id_sr_next  = IDW'(ident_reg);
                        cnt_next    = '0;
                        state_next  = S_ID;
                    end
                    else if (command > CMD_FINAL || err_reg != ST_OK)
                    begin
                        state_next = S_ONE;
                    end
                    else if (cmd_t'(command) == CMD_FINAL)
                    begin
                        if (!open_reg)
                        begin
                            err_next    = ST_NO_START;
                            one_st_next = ST_NO_START;
                        end
                        else if (closed_reg)
                        begin
                            one_st_next = ST_OK;
                        end
                        else
                        begin
                            closed_next = 1'b1;
                            cnt_next    = '0;
                            state_next  = S_FIN;
                        end
                    end
                    else if (closed_reg)
                    begin
                        err_next    = ST_AFTER_FIN;
                        one_st_next = ST_AFTER_FIN;
                    end
                    else if (!open_reg)
                    begin
                        err_next    = ST_NO_START;
                        one_st_next = ST_NO_START;
                    end
                    else if (cmd_t'(command) == CMD_FIELD)
                    begin
                        ch_next      = CH_COMMA;
                        one_cv_next  = 1'b1;
                        one_st_next  = ST_OK;
                        one_xor_next = 1'b1;
                    end
                    else if (cmd_t'(command) == CMD_BYTE)
                    begin
                        ch_next      = field_value[7:0];
                        one_cv_next  = 1'b1;
                        one_st_next  = ST_OK;
                        one_xor_next = 1'b1;
                    end
                    else
                    begin
                        // Integer: take the magnitude and feed the converter
                        neg_next   = int_val[NB-1];
                        mag_next   = int_val[NB-1] ? NB'(~int_val + NB'(1)) : int_val;
                        bcd_next   = '0;
                        cnt_next   = '0;
                        state_next = S_CONV;
                    end
                end
            end
            S_ONE:
            begin
                if (emit_fire)
                    state_next = S_IDLE;
            end
            S_ID:
            begin
                if (emit_fire)
                begin
                    if (cnt_reg != '0)
                        id_sr_next = id_sr_reg << 8;
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (emit_last)
                        state_next = S_IDLE;
                end
            end
            S_FIN:
            begin
                if (emit_fire)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (emit_last)
                        state_next = S_IDLE;
                end
            end
            S_CONV:
            begin
                // One magnitude bit per cycle into the BCD register
                {bcd_next, mag_next} = {bcd_adj, mag_reg} << 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NB - 1))
                begin
                    cnt_next   = CNT_W'(ND);
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                // Drop leading zero digits, keep at least one
                if (top_digit == 4'd0 && cnt_reg > CNT_W'(1))
                begin
                    bcd_next = bcd_reg << 4;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    state_next = S_COMMA;
                end
            end
            S_COMMA:
            begin
                if (emit_fire)
                    state_next = neg_reg ? S_MINUS : S_DIG;
            end
            S_MINUS:
            begin
                if (emit_fire)
                    state_next = S_DIG;
            end
            S_DIG:
            begin
                if (emit_fire)
                begin
                    bcd_next = bcd_reg << 4;
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (emit_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            xor_reg       <= 8'h00;
            open_reg      <= 1'b0;
            closed_reg    <= 1'b0;
            err_reg       <= ST_OK;
            ident_reg     <= '0;
            crlf_reg      <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            xor_reg    <= xor_next;
            open_reg   <= open_next;
            closed_reg <= closed_next;
            err_reg    <= err_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_IDENT: ident_reg <= cfg_data[ID_REG_W-1:0];
                    REG_CRLF:  crlf_reg  <= cfg_data[0];
                    default:   crlf_reg  <= crlf_reg;
                endcase
            end
            if (emit_fire)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        id_sr_reg   <= id_sr_next;
        ch_reg      <= ch_next;
        one_cv_reg  <= one_cv_next;
        one_st_reg  <= one_st_next;
        one_xor_reg <= one_xor_next;
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        neg_reg     <= neg_next;
        if (emit_fire)
        begin
            out_char_reg   <= emit_cv ? emit_char : 8'h00;
            char_valid_reg <= emit_cv;
            run_last_reg   <= emit_last;
            status_reg     <= emit_st;
        end
    end

    assign res_valid  = res_valid_reg;
    assign out_char   = out_char_reg;
    assign char_valid = char_valid_reg;
    assign run_last   = run_last_reg;
    assign status     = status_reg;

    // Checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_status_beat_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !char_valid |-> run_last)
        else $error("status-only beat not marked last");

    a_char_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && char_valid |-> status == ST_OK)
        else $error("character beat carries nonzero status");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command accepted while previous one in work");

endmodule

`default_nettype wire

[sim/nmea_sentence_builder_unit_tb.sv]
// Self-checking testbench for nmea_sentence_builder_unit: directed and random
// command streams, checked beat by beat by a predicting scoreboard.
// Depends on nmea_sb_pkg and nmea_sentence_builder_unit.
`default_nettype none

module nmea_sentence_builder_unit_tb;
    import nmea_sb_pkg::*;

    localparam int ID_CHARS = ID_CHARS_DEF;
    localparam int WATCHDOG_LIMIT = 3000;   // cycles with no beat on either channel
    localparam int SETTLE_CYCLES = 60;      // > integer conversion plus digit run
    localparam int HOLD_CYCLES = 300;       // long receiver hold-off
    localparam int RANDOM_PHASES = 5;
    localparam int ITEMS_PER_PHASE = 23;

    // Command codes the block does not define
    localparam logic [2:0] CMD_RSVD_LO = 3'd5;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;

    localparam logic [8*16-1:0] HEX_DIGITS = "0123456789ABCDEF";
    localparam logic [ID_REG_W-1:0] ID_GPGGA = "GPGGA";
    localparam logic [ID_REG_W-1:0] ID_GNRMC = "GNRMC";
    localparam logic [ID_REG_W-1:0] ID_ALL_ONES = '1;

    typedef struct {
        logic [7:0] ch;
        logic       has_char;
        logic       last;
        logic [1:0] st;
    } beat_t;

    // Tracks the sentence state, predicts the beats each command causes and
    // checks the result stream against them in order.
    class sentence_scoreboard;
        logic [ID_REG_W-1:0] ident;
        logic                crlf_en;
        logic [7:0]          run_xor;
        bit                  open_s;
        bit                  closed_s;
        logic [1:0]          err;
        beat_t               due_beats[$];
        int                  mismatches;
        int                  beats_seen;
        int                  cmds_seen;
        int                  int_fields;

        function new();
            ident = '0;
            crlf_en = 1'b1;
            run_xor = '0;
            open_s = 0;
            closed_s = 0;
            err = ST_OK;
            mismatches = 0;
            beats_seen = 0;
            cmds_seen = 0;
            int_fields = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_IDENT)
                ident = data[ID_REG_W-1:0];
            else if (idx == REG_CRLF)
                crlf_en = data[0];
        endfunction

        function void push_char(logic [7:0] c, bit in_sum);
            beat_t b;
            b.ch = c;
            b.has_char = 1'b1;
            b.last = 1'b0;
            b.st = ST_OK;
            due_beats.insert(due_beats.size(), b);
            if (in_sum)
                run_xor ^= c;
        endfunction

        function void push_status(logic [1:0] s);
            beat_t b;
            b.ch = 8'h00;
            b.has_char = 1'b0;
            b.last = 1'b0;
            b.st = s;
            due_beats.insert(due_beats.size(), b);
        endfunction

        // Signed decimal text of a 32-bit two's complement value, after a comma
        function void push_decimal(logic [31:0] v);
            logic [31:0] mag;
            int unsigned rest;
            logic [7:0] digs[$];
            push_char(CH_COMMA, 1);
            mag = v[31] ? (~v + 32'd1) : v;
            if (v[31])
                push_char(CH_MINUS, 1);
            rest = mag;
            do begin
                digs.push_front(CH_ZERO + 8'(rest % 10));
                rest = rest / 10;
            end while (rest != 0);
            foreach (digs[i])
                push_char(digs[i], 1);
        endfunction

        function void note_command(logic [2:0] cmd, logic [31:0] fv);
            int first;
            first = due_beats.size();
            cmds_seen++;
            if (cmd == CMD_START) begin
                err = ST_OK;
                open_s = 1;
                closed_s = 0;
                run_xor = '0;
                push_char(CH_DOLLAR, 0);
                for (int i = ID_CHARS - 1; i >= 0; i--)
                    push_char(ident[8*i +: 8], 1);
            end else if (cmd > CMD_FINAL || err != ST_OK) begin
                push_status(err);
            end else if (cmd == CMD_FINAL) begin
                if (!open_s) begin
                    err = ST_NO_START;
                    push_status(err);
                end else if (closed_s) begin
                    push_status(ST_OK);
                end else begin
                    push_char(CH_STAR, 0);
                    push_char(HEX_DIGITS[8*(15 - run_xor[7:4]) +: 8], 0);
                    push_char(HEX_DIGITS[8*(15 - run_xor[3:0]) +: 8], 0);
                    if (crlf_en) begin
                        push_char(CH_CR, 0);
                        push_char(CH_LF, 0);
                    end
                    closed_s = 1;
                end
            end else if (closed_s) begin
                err = ST_AFTER_FIN;
                push_status(err);
            end else if (!open_s) begin
                err = ST_NO_START;
                push_status(err);
            end else if (cmd == CMD_FIELD) begin
                push_char(CH_COMMA, 1);
            end else if (cmd == CMD_BYTE) begin
                push_char(fv[7:0], 1);
            end else begin
                int_fields++;
                push_decimal(fv);
            end
            if (due_beats.size() > first)
                due_beats[due_beats.size() - 1].last = 1'b1;
        endfunction

        function void check_beat(logic [7:0] ch, logic has_char, logic last, logic [1:0] st);
            beat_t e;
            beats_seen++;
            if (due_beats.size() == 0) begin
                $display("%0t: exp no beat, act char=%h valid=%b last=%b status=%0d",
                         $time, ch, has_char, last, st);
                mismatches++;
                return;
            end
            e = due_beats.pop_front();
            if (ch !== e.ch) begin
                $display("%0t: out_char exp %h act %h", $time, e.ch, ch);
                mismatches++;
            end
            if (has_char !== e.has_char) begin
                $display("%0t: char_valid exp %b act %b", $time, e.has_char, has_char);
                mismatches++;
            end
            if (last !== e.last) begin
                $display("%0t: run_last exp %b act %b", $time, e.last, last);
                mismatches++;
            end
            if (st !== e.st) begin
                $display("%0t: status exp %0d act %0d", $time, e.st, st);
                mismatches++;
            end
        endfunction

        // Anything still owed at the end is a failure
        function void close_out();
            if (due_beats.size() != 0) begin
                $display("%0t: %0d beats never arrived, next exp char=%h status=%0d",
                         $time, due_beats.size(), due_beats[0].ch, due_beats[0].st);
                mismatches += due_beats.size();
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cmd_valid;
    logic                  cmd_ready;
    logic [2:0]            command;
    logic signed [31:0]    field_value;
    logic                  res_valid;
    logic                  res_ready;
    logic [7:0]            out_char;
    logic                  char_valid;
    logic                  run_last;
    logic [1:0]            status;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sentence_scoreboard sb;

    // Sender and receiver shaping, set by the main sequence between phases
    int         burst_left;
    int         max_gap;
    logic [7:0] rx_pattern;
    int         hold_reqs;
    int         settings_seen;

    nmea_sentence_builder_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .command     (command),
        .field_value (field_value),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .out_char    (out_char),
        .char_valid  (char_valid),
        .run_last    (run_last),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: check every beat the receiver takes, in arrival order
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            sb.check_beat(out_char, char_valid, run_last, status);
    end

    // Receiver: walk the stall pattern, occasionally slip its phase, and hold
    // off completely for a long stretch whenever the main sequence asks.
    initial
    begin
        int seen;
        int hold_left;
        int step;
        seen = 0;
        hold_left = 0;
        step = 0;
        res_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_reqs != seen) begin
                seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ready <= 1'b0;
            end else begin
                res_ready <= rx_pattern[step];
                step = (step + 1 + ($urandom_range(0, 15) == 0 ? 1 : 0)) % 8;
            end
        end
    end

    // Watchdog: end the run if neither channel moves a beat for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: watchdog expired with %0d beats outstanding", $time,
                 sb.due_beats.size());
        $display("nmea_sentence_builder_unit_tb: FAIL");
        $finish;
    end

    // Write one register; the model takes the same value at the same time
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        sb.set_reg(idx, data);
        settings_seen++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one command and hold it until accepted; bursts end with a random gap
    task automatic send_command(input logic [2:0] cmd, input logic [31:0] fv);
        int gap;
        @(negedge clk);
        cmd_valid <= 1'b1;
        command <= cmd;
        field_value <= fv;
        do
            @(posedge clk);
        while (!cmd_ready);
        sb.note_command(cmd, fv);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, max_gap);
            if (gap != 0) begin
                @(negedge clk);
                cmd_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // Drop valid so an accepted payload is never offered twice, then wait
    // for every owed beat plus the block's settle time.
    task automatic drain_block();
        if (cmd_valid) begin
            @(negedge clk);
            cmd_valid <= 1'b0;
        end
        burst_left = 0;
        while (sb.due_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Integer field values: full range, small of either sign, and the edges
    function automatic logic [31:0] pick_int_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 99);
            2: return -$urandom_range(1, 999);
            default:
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h8000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
        endcase
    endfunction

    // Mostly whole sentences with random fields; the rest abandoned
    // sentences, writes after finalize, repeated finalize and plain noise.
    task automatic build_random_sentences(input int n_items);
        int sent;
        int n_fields;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 80) begin
                send_command(CMD_START, $urandom);
                sent++;
                n_fields = $urandom_range(0, 6);
                repeat (n_fields) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 5)
                        send_command(CMD_FIELD, $urandom);
                    else if (pick < 11)
                        send_command(CMD_BYTE, $urandom);
                    else if (pick < 19)
                        send_command(CMD_INT, pick_int_value());
                    else
                        send_command(3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI)), $urandom);
                    sent++;
                end
                // Leave some sentences open so the next start discards them
                if ($urandom_range(0, 9) != 0) begin
                    send_command(CMD_FINAL, $urandom);
                    sent++;
                    pick = $urandom_range(0, 9);
                    if (pick == 0) begin
                        send_command(CMD_FINAL, $urandom);
                        sent++;
                    end else if (pick == 1) begin
                        send_command(3'($urandom_range(CMD_FIELD, CMD_INT)), pick_int_value());
                        send_command(3'($urandom_range(CMD_FIELD, CMD_FINAL)), $urandom);
                        sent += 2;
                    end
                end
            end else begin
                send_command(3'($urandom_range(0, 7)), $urandom);
                sent++;
            end
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        command = CMD_START;
        field_value = '0;
        cfg_we = 1'b0;
        cfg_index = REG_IDENT;
        cfg_data = '0;
        burst_left = 0;
        max_gap = 4;
        rx_pattern = 8'b1110_1101;
        hold_reqs = 0;
        settings_seen = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed: errors before any start, then one sentence through every
        // command and the integer extremes, then the after-finalize cases and a restart.
        write_reg(REG_IDENT, ID_GPGGA);
        write_reg(REG_CRLF, 1);
        send_command(CMD_FINAL, 32'd0);          // finalize with nothing started
        send_command(CMD_FIELD, 32'd0);          // sticky no-start error
        send_command(CMD_RSVD_HI, 32'hFFFF_FFFF);
        send_command(CMD_START, 32'd0);          // clears the error
        send_command(CMD_FIELD, 32'd0);
        send_command(CMD_BYTE, 32'hFFFF_FF00);   // only the low byte counts
        send_command(CMD_BYTE, 32'h0000_00FF);
        send_command(CMD_INT, 32'h0000_0000);
        send_command(CMD_INT, 32'h7FFF_FFFF);
        send_command(CMD_INT, 32'h8000_0000);
        send_command(CMD_INT, 32'hFFFF_FFFF);
        send_command(CMD_RSVD_LO, 32'h5555_AAAA);
        send_command(CMD_FINAL, 32'd0);
        send_command(CMD_FINAL, 32'd0);          // repeated finalize is a no-op
        send_command(CMD_BYTE, 32'h41);          // write after finalize
        send_command(CMD_FIELD, 32'd0);
        send_command(CMD_FINAL, 32'd0);
        send_command(CMD_START, 32'd0);
        send_command(CMD_INT, 32'd12345);
        send_command(CMD_START, 32'd0);          // restart mid-sentence
        send_command(CMD_BYTE, 32'h41);
        send_command(CMD_FINAL, 32'd0);
        drain_block();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_IDENT, '0);
                    write_reg(REG_CRLF, 0);
                    rx_pattern = 8'hFF;
                    max_gap = 0;
                end
                1: begin
                    write_reg(REG_IDENT, ID_ALL_ONES);
                    write_reg(REG_CRLF, 1);
                    rx_pattern = 8'b1101_0110;
                    max_gap = 6;
                    hold_reqs++;                 // fill the block while the receiver waits
                end
                2: begin
                    write_reg(REG_IDENT, {$urandom, $urandom});
                    write_reg(REG_CRLF, 1'($urandom));
                    rx_pattern = 8'($urandom) | 8'h01;
                    max_gap = 10;
                end
                3: begin
                    write_reg(REG_IDENT, ID_GNRMC);
                    write_reg(REG_CRLF, 0);
                    rx_pattern = 8'b0100_1001;
                    max_gap = 3;
                end
                default: begin
                    write_reg(REG_IDENT, {$urandom, $urandom});
                    write_reg(REG_CRLF, 1);
                    rx_pattern = 8'($urandom) | 8'h01;
                    max_gap = 15;
                end
            endcase
            build_random_sentences(ITEMS_PER_PHASE);
            drain_block();
        end

        sb.close_out();
        $display("Covered %0d commands (%0d integer fields), %0d result beats checked,",
                 sb.cmds_seen, sb.int_fields, sb.beats_seen);
        $display("%0d register writes across %0d configurations, %0d mismatches.",
                 settings_seen, RANDOM_PHASES + 1, sb.mismatches);
        if (sb.mismatches == 0)
            $display("nmea_sentence_builder_unit_tb: PASS");
        else
            $display("nmea_sentence_builder_unit_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[nmea_sentence_builder_unit.f]
src/nmea_sb_pkg.sv
src/nmea_sentence_builder_unit.sv
sim/nmea_sentence_builder_unit_tb.sv
